>>> rtl/upce_pkg.sv
// Package for the URI component percent encoder.
// Holds the word types, surrogate constants and the unescaped-set check.
// No dependencies.
package upce_pkg;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        end_of_string;
  } in_word_t;

  typedef struct packed {
    logic [6:0] out_char;
    logic       last_of_run;
    logic       malformed;
  } out_word_t;

  localparam logic [5:0]  SurrHighTag = 6'b110110;
  localparam logic [5:0]  SurrLowTag  = 6'b110111;
  localparam logic [20:0] SuppBase    = 21'h10000;
  localparam logic [6:0]  CharPercent = 7'h25;
  localparam logic [6:0]  CharZero    = 7'h30;
  localparam logic [6:0]  CharUpperA  = 7'h41;

  localparam out_word_t ErrorWord = '{out_char: 7'd0, last_of_run: 1'b1, malformed: 1'b1};

  function automatic logic is_unescaped(input logic [15:0] c);
    logic r;
    r = 1'b0;
    if (c >= 16'h41 && c <= 16'h5A) r = 1'b1;
    if (c >= 16'h61 && c <= 16'h7A) r = 1'b1;
    if (c >= 16'h30 && c <= 16'h39) r = 1'b1;
    if (c == 16'h2D || c == 16'h5F || c == 16'h2E || c == 16'h21 || c == 16'h7E ||
        c == 16'h2A || c == 16'h27 || c == 16'h28 || c == 16'h29) r = 1'b1;
    return r;
  endfunction

endpackage

>>> rtl/uri_component_percent_encoder.sv
// Top level of the URI component percent encoder: sequencer and output register.
// Depends on upce_pkg, upce_octet_gen and upce_hex_digit.
//
// Input words carry one UTF-16 code unit and an end-of-string flag on a
// valid/ready channel; output words carry one ASCII character, a last-of-run
// flag and a malformed flag on a second valid/ready channel.
// An unescaped unit or an error gives one output word; it is held in the
// sequencer and then loaded into the output register. Any other unit gives
// three words per UTF-8 octet (1 to 4 octets) from the shared octet selector
// and hex digit converter, one word per cycle while the receiver does not stall.
// A high surrogate in the middle of a string gives no word and is held.
// The input is not ready while a unit is being emitted; the next unit is
// taken in the cycle after the last word of the current one is loaded.
// When the receiver stalls, the output register holds its word and the
// sequencer waits. Reset clears the held surrogate, the sequencer and the
// output register valid.
module uri_component_percent_encoder (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  upce_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output upce_pkg::out_word_t out_word_o
);
  import upce_pkg::*;

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StSingle = 2'd1;
  localparam logic [1:0] StEsc    = 2'd2;

  localparam logic [1:0] ChrPct = 2'd0;
  localparam logic [1:0] ChrHi  = 2'd1;
  localparam logic [1:0] ChrLo  = 2'd2;

  logic [1:0]  state_q, state_d;
  logic        pend_valid_q, pend_valid_d;
  logic [9:0]  pend_hi_q, pend_hi_d;
  logic [20:0] cp_q, cp_d;
  logic [1:0]  n_last_q, n_last_d;
  logic [1:0]  oct_idx_q, oct_idx_d;
  logic [1:0]  chr_idx_q, chr_idx_d;
  out_word_t   single_q, single_d;
  logic        out_valid_q, out_valid_d;
  out_word_t   out_word_q, out_word_d;

  logic        accept;
  logic        load;
  logic        is_low;
  logic        is_high;
  logic [15:0] cu;
  logic [7:0]  octet;
  logic [3:0]  nibble;
  logic [6:0]  hex_char;
  out_word_t   esc_word;
  logic        esc_last;

  assign cu         = in_word_i.code_unit;
  assign is_low     = cu[15:10] == SurrLowTag;
  assign is_high    = cu[15:10] == SurrHighTag;
  assign in_ready_o = state_q == StIdle;
  assign accept     = in_valid_i && in_ready_o;
  assign load       = (state_q != StIdle) && (!out_valid_q || out_ready_i);

  upce_octet_gen u_octet_gen (
    .cp_i      (cp_q),
    .n_last_i  (n_last_q),
    .oct_idx_i (oct_idx_q),
    .octet_o   (octet)
  );

  assign nibble = (chr_idx_q == ChrHi) ? octet[7:4] : octet[3:0];

  upce_hex_digit u_hex_digit (
    .nibble_i (nibble),
    .char_o   (hex_char)
  );

  assign esc_last = (chr_idx_q == ChrLo) && (oct_idx_q == n_last_q);

  always_comb begin
    esc_word.out_char    = (chr_idx_q == ChrPct) ? CharPercent : hex_char;
    esc_word.last_of_run = esc_last;
    esc_word.malformed   = 1'b0;
  end

  always_comb begin
    state_d      = state_q;
    pend_valid_d = pend_valid_q;
    pend_hi_d    = pend_hi_q;
    cp_d         = cp_q;
    n_last_d     = n_last_q;
    oct_idx_d    = oct_idx_q;
    chr_idx_d    = chr_idx_q;
    single_d     = single_q;
    if (accept) begin
      oct_idx_d = 2'd0;
      chr_idx_d = ChrPct;
      if (pend_valid_q) begin
        pend_valid_d = 1'b0;
        pend_hi_d    = 10'd0;
        if (!is_low) begin
          single_d = ErrorWord;
          state_d  = StSingle;
        end else begin
          cp_d    = {1'b0, pend_hi_q, cu[9:0]} + SuppBase;
          state_d = StEsc;
        end
      end else if (is_unescaped(cu)) begin
        single_d = '{out_char: cu[6:0], last_of_run: 1'b1, malformed: 1'b0};
        state_d  = StSingle;
      end else if (is_low || (is_high && in_word_i.end_of_string)) begin
        single_d = ErrorWord;
        state_d  = StSingle;
      end else if (is_high) begin
        pend_valid_d = 1'b1;
        pend_hi_d    = cu[9:0];
      end else begin
        cp_d    = {5'd0, cu};
        state_d = StEsc;
      end
      if (cp_d < 21'h80) begin
        n_last_d = 2'd0;
      end else if (cp_d < 21'h800) begin
        n_last_d = 2'd1;
      end else if (cp_d < 21'h10000) begin
        n_last_d = 2'd2;
      end else begin
        n_last_d = 2'd3;
      end
    end else if (load) begin
      case (state_q)
        StSingle: begin
          state_d = StIdle;
        end
        StEsc: begin
          if (chr_idx_q == ChrLo) begin
            chr_idx_d = ChrPct;
            if (esc_last) begin
              state_d = StIdle;
            end else begin
              oct_idx_d = oct_idx_q + 2'd1;
            end
          end else begin
            chr_idx_d = chr_idx_q + 2'd1;
          end
        end
        default: begin
          state_d = StIdle;
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_word_d  = out_word_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (load) begin
      out_valid_d = 1'b1;
      out_word_d  = (state_q == StSingle) ? single_q : esc_word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      pend_valid_q <= 1'b0;
      pend_hi_q    <= 10'd0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      pend_valid_q <= pend_valid_d;
      pend_hi_q    <= pend_hi_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cp_q       <= cp_d;
    n_last_q   <= n_last_d;
    oct_idx_q  <= oct_idx_d;
    chr_idx_q  <= chr_idx_d;
    single_q   <= single_d;
    out_word_q <= out_word_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

>>> rtl/upce_octet_gen.sv
// UTF-8 octet selector: picks one octet of a code point's encoding by index.
// Depends on upce_pkg.
module upce_octet_gen (
  input  logic [20:0] cp_i,
  input  logic [1:0]  n_last_i,
  input  logic [1:0]  oct_idx_i,
  output logic [7:0]  octet_o
);
  import upce_pkg::*;

  logic [1:0] pos;
  logic [5:0] cont;

  assign pos = n_last_i - oct_idx_i;

  always_comb begin
    case (pos)
      2'd0:    cont = cp_i[5:0];
      2'd1:    cont = cp_i[11:6];
      2'd2:    cont = cp_i[17:12];
      2'd3:    cont = {3'b000, cp_i[20:18]};
      default: cont = cp_i[5:0];
    endcase
  end

  always_comb begin
    if (oct_idx_i == 2'd0) begin
      case (n_last_i)
        2'd0:    octet_o = {1'b0, cp_i[6:0]};
        2'd1:    octet_o = {3'b110, cp_i[10:6]};
        2'd2:    octet_o = {4'b1110, cp_i[15:12]};
        2'd3:    octet_o = {5'b11110, cp_i[20:18]};
        default: octet_o = {1'b0, cp_i[6:0]};
      endcase
    end else begin
      octet_o = {2'b10, cont};
    end
  end

endmodule

>>> rtl/upce_hex_digit.sv
// Shared nibble to uppercase ASCII hex digit converter.
// Depends on upce_pkg.
module upce_hex_digit (
  input  logic [3:0] nibble_i,
  output logic [6:0] char_o
);
  import upce_pkg::*;

  always_comb begin
    if (nibble_i < 4'd10) begin
      char_o = CharZero + {3'b000, nibble_i};
    end else begin
      char_o = CharUpperA + {3'b000, nibble_i} - 7'd10;
    end
  end

endmodule
